// ----- rtl/max_heap_priority_queue_macros.svh -----
// assertion helpers shared by the heap rtl
// both sample on clk and are disabled while arst_n is low
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define MHPQ_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants of the max-heap priority queue: request and result
// payloads, operation and status codes, heap geometry and controller states.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// heap geometry
	localparam int DEPTH     = 1024;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int XW        = ADDR_W + 2;
	localparam int VAL_W     = 32;
	localparam int OUT_CNT_W = 11;

	// operation codes
	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  top_value;
		logic                     top_valid;
		logic [OUT_CNT_W-1:0]     entry_count;
		logic signed [VAL_W-1:0]  removed_value;
		status_t                  status;
	} rsp_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP,
		ST_UP_ROOT,
		ST_DN_LOAD,
		ST_DN_LEFT,
		ST_DN_RIGHT,
		ST_DN_PUT,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/max_heap_priority_queue.sv -----
// A push climbs the new value level by level while it is larger than its parent;
// a pop moves the last entry to the root and sinks it, reading the left child and
// then the right child (where there is one) at each level, since the two reads share
// the single read port of the heap memory. One request is in work at a time; a new
// request is taken as soon as the previous result is in the output register, even
// while that result waits. Push on a full heap and pop on an empty heap return at
// once with a status.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values in a single-port-read, single-port-
// write memory. Sifts move a hole instead of swapping, and a root copy is
// kept in a register so the maximum is always at hand.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_macros.svh"

module max_heap_priority_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  mhpq_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mhpq_pkg::rsp_t  rsp
);

	// heap memory and read register
	logic signed [mhpq_pkg::VAL_W-1:0]   heap_mem_q [mhpq_pkg::DEPTH];
	logic signed [mhpq_pkg::VAL_W-1:0]   rd_data_q;

	// control state
	mhpq_pkg::state_t                    state_q, state_d;
	logic [mhpq_pkg::CNT_W-1:0]          count_q, count_d;
	logic                                rsp_valid_q;

	// working payload
	logic [mhpq_pkg::ADDR_W-1:0]         pos_q, pos_d;
	logic signed [mhpq_pkg::VAL_W-1:0]   val_q, val_d;
	logic signed [mhpq_pkg::VAL_W-1:0]   left_q;
	logic signed [mhpq_pkg::VAL_W-1:0]   removed_q, removed_d;
	logic signed [mhpq_pkg::VAL_W-1:0]   top_q;
	mhpq_pkg::status_t                   status_q, status_d;
	mhpq_pkg::rsp_t                      rsp_q;

	// memory port controls
	logic                                rd_en, wr_en;
	logic [mhpq_pkg::ADDR_W-1:0]         rd_addr, wr_addr;
	logic signed [mhpq_pkg::VAL_W-1:0]   wr_data;

	// decisions
	logic                                acc_cmd, full, empty, rsp_load;
	logic                                push_ok, pop_ok, wr_in_heap;
	logic [mhpq_pkg::ADDR_W-1:0]         parent_idx, push_parent;
	logic                                up_gt;
	logic [mhpq_pkg::XW-1:0]             cnt_x, left_x, right_x, nleft_x, dn_idx_x;
	logic signed [mhpq_pkg::VAL_W-1:0]   dn_cand;
	logic [mhpq_pkg::ADDR_W-1:0]         dn_idx;
	logic                                dn_gt, has_right, nleft_has;

	assign cmd_stall = (state_q != mhpq_pkg::ST_IDLE);
	assign acc_cmd   = cmd_valid && !cmd_stall;
	assign full      = (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign rsp_load  = (state_q == mhpq_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// accepted requests that change the heap
	assign push_ok   = acc_cmd && (cmd.kind == mhpq_pkg::KIND_PUSH) && !full;
	assign pop_ok    = acc_cmd && (cmd.kind == mhpq_pkg::KIND_POP) && !empty;

	// sift-up index math
	assign parent_idx  = mhpq_pkg::ADDR_W'((pos_q - 1'b1) >> 1);
	assign push_parent = mhpq_pkg::ADDR_W'((count_q - 1'b1) >> 1);
	assign up_gt       = (val_q > rd_data_q);

	// sift-down child selection, left child wins a tie
	assign cnt_x     = mhpq_pkg::XW'(count_q);
	assign left_x    = {1'b0, pos_q, 1'b1};
	assign right_x   = left_x + 1'b1;
	assign has_right = (right_x < cnt_x);
	always_comb begin
		dn_cand  = rd_data_q;
		dn_idx_x = left_x;
		if (state_q == mhpq_pkg::ST_DN_RIGHT && rd_data_q > left_q) begin
			dn_cand  = rd_data_q;
			dn_idx_x = right_x;
		end else if (state_q == mhpq_pkg::ST_DN_RIGHT) begin
			dn_cand  = left_q;
			dn_idx_x = left_x;
		end
	end
	assign dn_idx    = dn_idx_x[mhpq_pkg::ADDR_W-1:0];
	assign dn_gt     = (dn_cand > val_q);
	assign nleft_x   = {1'b0, dn_idx, 1'b1};
	assign nleft_has = (nleft_x < cnt_x);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (acc_cmd) begin
					if (cmd.kind == mhpq_pkg::KIND_PUSH && !full && !empty) begin
						state_d = mhpq_pkg::ST_UP;
					end else if (cmd.kind == mhpq_pkg::KIND_POP && count_q > 1) begin
						state_d = mhpq_pkg::ST_DN_LOAD;
					end else begin
						state_d = mhpq_pkg::ST_DONE;
					end
				end
			end
			mhpq_pkg::ST_UP: begin
				if (!up_gt) begin
					state_d = mhpq_pkg::ST_DONE;
				end else if (parent_idx == '0) begin
					state_d = mhpq_pkg::ST_UP_ROOT;
				end
			end
			mhpq_pkg::ST_UP_ROOT: state_d = mhpq_pkg::ST_DONE;
			mhpq_pkg::ST_DN_LOAD: begin
				state_d = (cnt_x > 1) ? mhpq_pkg::ST_DN_LEFT : mhpq_pkg::ST_DONE;
			end
			mhpq_pkg::ST_DN_LEFT, mhpq_pkg::ST_DN_RIGHT: begin
				if (state_q == mhpq_pkg::ST_DN_LEFT && has_right) begin
					state_d = mhpq_pkg::ST_DN_RIGHT;
				end else if (!dn_gt) begin
					state_d = mhpq_pkg::ST_DONE;
				end else if (nleft_has) begin
					state_d = mhpq_pkg::ST_DN_LEFT;
				end else begin
					state_d = mhpq_pkg::ST_DN_PUT;
				end
			end
			mhpq_pkg::ST_DN_PUT: state_d = mhpq_pkg::ST_DONE;
			mhpq_pkg::ST_DONE: begin
				if (rsp_load) begin
					state_d = mhpq_pkg::ST_IDLE;
				end
			end
			default: state_d = mhpq_pkg::ST_IDLE;
		endcase
	end

	// memory controls and working register updates
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = val_q;
		count_d   = count_q;
		pos_d     = pos_q;
		val_d     = val_q;
		removed_d = removed_q;
		status_d  = status_q;
		unique case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (acc_cmd) begin
					removed_d = '0;
					status_d  = mhpq_pkg::STATUS_OK;
					if (cmd.kind == mhpq_pkg::KIND_PUSH) begin
						if (full) begin
							status_d = mhpq_pkg::STATUS_FULL;
						end else begin
							count_d = count_q + 1'b1;
							pos_d   = count_q[mhpq_pkg::ADDR_W-1:0];
							val_d   = cmd.value;
							if (empty) begin
								wr_en   = 1'b1;
								wr_addr = '0;
								wr_data = cmd.value;
							end else begin
								rd_en   = 1'b1;
								rd_addr = push_parent;
							end
						end
					end else begin
						if (empty) begin
							status_d = mhpq_pkg::STATUS_EMPTY;
						end else begin
							count_d   = count_q - 1'b1;
							removed_d = top_q;
							pos_d     = '0;
							rd_en     = 1'b1;
							rd_addr   = mhpq_pkg::ADDR_W'(count_q - 1'b1);
						end
					end
				end
			end
			mhpq_pkg::ST_UP: begin
				wr_en = 1'b1;
				if (up_gt) begin
					// parent moves down into the hole
					wr_data = rd_data_q;
					pos_d   = parent_idx;
					rd_en   = 1'b1;
					rd_addr = mhpq_pkg::ADDR_W'((parent_idx - 1'b1) >> 1);
				end
			end
			mhpq_pkg::ST_UP_ROOT: wr_en = 1'b1;
			mhpq_pkg::ST_DN_LOAD: begin
				val_d = rd_data_q;
				if (cnt_x > 1) begin
					rd_en   = 1'b1;
					rd_addr = mhpq_pkg::ADDR_W'(1);
				end else begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
				end
			end
			mhpq_pkg::ST_DN_LEFT, mhpq_pkg::ST_DN_RIGHT: begin
				if (state_q == mhpq_pkg::ST_DN_LEFT && has_right) begin
					rd_en   = 1'b1;
					rd_addr = right_x[mhpq_pkg::ADDR_W-1:0];
				end else begin
					wr_en = 1'b1;
					if (dn_gt) begin
						// larger child moves up into the hole
						wr_data = dn_cand;
						pos_d   = dn_idx;
						if (nleft_has) begin
							rd_en   = 1'b1;
							rd_addr = nleft_x[mhpq_pkg::ADDR_W-1:0];
						end
					end
				end
			end
			mhpq_pkg::ST_DN_PUT: wr_en = 1'b1;
			mhpq_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// writes stay below the count that holds after this cycle
	assign wr_in_heap = (mhpq_pkg::XW'(wr_addr) < mhpq_pkg::XW'(count_d));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mhpq_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		val_q     <= val_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		if (state_q == mhpq_pkg::ST_DN_LEFT) begin
			left_q <= rd_data_q;
		end
		// root copy follows every write to the root entry
		if (wr_en && wr_addr == '0) begin
			top_q <= wr_data;
		end
		if (rsp_load) begin
			rsp_q.top_value     <= empty ? '0 : top_q;
			rsp_q.top_valid     <= !empty;
			rsp_q.entry_count   <= mhpq_pkg::OUT_CNT_W'(count_q);
			rsp_q.removed_value <= removed_q;
			rsp_q.status        <= status_q;
		end
	end

	// heap memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= heap_mem_q[rd_addr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`MHPQ_ASSERT(a_count_range, 1'b1, count_q <= mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH), "count above depth")
	`MHPQ_ASSERT(a_wr_in_heap, wr_en, wr_in_heap, "write beyond last entry")
	`MHPQ_ASSERT_NEXT(a_push_grows, push_ok, count_q == $past(count_q) + 1'b1, "push did not grow count")
	`MHPQ_ASSERT_NEXT(a_pop_takes_root, pop_ok, removed_q == $past(top_q), "pop did not take root")

endmodule
